@@ src/hbis_pkg.sv @@
package hbis_pkg;

	localparam int VAL_W = 63;
	localparam int GROWTH_W = 32;
	localparam int CNT_W = 11;
	localparam int IDX_W = 12;
	localparam int CFG_ADDR_W = 8;
	localparam int CFG_DATA_W = 64;

	localparam logic [VAL_W-1:0] SAT_MAX = {VAL_W{1'b1}};

	localparam logic [CFG_ADDR_W-1:0] REG_BUCKET_WIDTH = 8'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GROWTH_RATIO = 8'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_EXP_SCALE    = 8'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_BUCKET_COUNT = 8'd3;

	localparam logic [VAL_W-1:0] EXP_SCALE_RST = 63'd65536;
	localparam logic [CNT_W-1:0] BUCKET_COUNT_RST = 11'd1;

	typedef struct packed {
		logic start;
		logic frac;
	} mul_ctl_t;

endpackage

@@ src/histogram_bucket_index_search.sv @@
// each probe of edge k runs a linear multiply, then k-1 growth steps (fewer once
// the exponential term reaches zero); an edge 0 probe with growth set uses the
// divider instead; up to ceil(log2(N+2)) probes, N the capped bucket count.
// one item at a time, busy until the result strobe; the terms share one multiplier.
// the result strobe done is high for one cycle and cannot be stalled.
// reset clears the sequencer and loads the configuration registers with their reset values.
module histogram_bucket_index_search #(
	parameter int MAX_BUCKETS = 1024,
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [63:0]                   sample_value,
	output logic                                 done,
	output logic signed [hbis_pkg::IDX_W-1:0]    bucket_index,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hbis_pkg::CFG_ADDR_W-1:0]      cfg_index,
	input  logic [hbis_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PROBE = 4'd1;
	localparam logic [3:0] S_LIN   = 4'd2;
	localparam logic [3:0] S_LIN_W = 4'd3;
	localparam logic [3:0] S_EXP   = 4'd4;
	localparam logic [3:0] S_EXP_W = 4'd5;
	localparam logic [3:0] S_DIV_W = 4'd6;
	localparam logic [3:0] S_SUM   = 4'd7;
	localparam logic [3:0] S_CMP   = 4'd8;

	logic [3:0]                          state_q;
	logic [hbis_pkg::VAL_W-1:0]          width_q;
	logic [hbis_pkg::GROWTH_W-1:0]       growth_q;
	logic [hbis_pkg::VAL_W-1:0]          scale_q;
	logic [hbis_pkg::CNT_W-1:0]          count_q;
	logic [hbis_pkg::CNT_W-1:0]          count_eff;
	logic [63:0]                         sample_q;
	logic [hbis_pkg::IDX_W-1:0]          lo_q;
	logic [hbis_pkg::IDX_W-1:0]          hi_q;
	logic [hbis_pkg::IDX_W-1:0]          mid_full;
	logic [hbis_pkg::CNT_W-1:0]          mid_q;
	logic [hbis_pkg::CNT_W-1:0]          exp_cnt_q;
	logic [hbis_pkg::VAL_W-1:0]          lin_q;
	logic [hbis_pkg::VAL_W-1:0]          term_q;
	logic [hbis_pkg::VAL_W-1:0]          edge_q;
	logic [hbis_pkg::VAL_W:0]            sum;
	logic                                done_q;
	logic [hbis_pkg::IDX_W-1:0]          index_q;
	logic [hbis_pkg::VAL_W-1:0]          mag;
	logic                                neg;

	hbis_pkg::mul_ctl_t                  mul_ctl;
	logic [hbis_pkg::VAL_W-1:0]          mul_a;
	logic                                mul_done;
	logic [hbis_pkg::VAL_W-1:0]          mul_res;
	logic                                div_start;
	logic                                div_done;
	logic [hbis_pkg::VAL_W-1:0]          div_res;

	assign cfg_ready = 1'b1;
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign bucket_index = index_q;

	assign count_eff = (32'(count_q) > 32'(MAX_BUCKETS)) ? hbis_pkg::CNT_W'(MAX_BUCKETS)
		: count_q;
	assign mid_full = lo_q + ((hi_q - lo_q) >> 1);
	assign neg = sample_q[63];
	assign mag = sample_q[hbis_pkg::VAL_W-1:0];
	assign sum = {1'b0, lin_q} + {1'b0, term_q};

	assign mul_ctl.start = (state_q == S_LIN) || (state_q == S_EXP && exp_cnt_q != '0
		&& term_q != '0);
	assign mul_ctl.frac = (state_q == S_EXP);
	assign mul_a = (state_q == S_LIN) ? width_q : term_q;
	assign div_start = (state_q == S_LIN_W) && mul_done && (growth_q != '0) && (mid_q == '0);

	hbis_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.a      (mul_a),
		.b      ((state_q == S_LIN) ? 32'(mid_q) : growth_q),
		.done   (mul_done),
		.res    (mul_res)
	);

	hbis_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (scale_q),
		.g      (growth_q),
		.done   (div_done),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
			growth_q <= '0;
			scale_q <= hbis_pkg::EXP_SCALE_RST;
			count_q <= hbis_pkg::BUCKET_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hbis_pkg::REG_BUCKET_WIDTH: width_q <= cfg_data[hbis_pkg::VAL_W-1:0];
				hbis_pkg::REG_GROWTH_RATIO: growth_q <= cfg_data[hbis_pkg::GROWTH_W-1:0];
				hbis_pkg::REG_EXP_SCALE:    scale_q <= cfg_data[hbis_pkg::VAL_W-1:0];
				hbis_pkg::REG_BUCKET_COUNT: count_q <= cfg_data[hbis_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_PROBE;
				S_PROBE: begin
					if (hi_q > lo_q) begin
						state_q <= S_LIN;
					end else begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_LIN: state_q <= S_LIN_W;
				S_LIN_W: begin
					if (mul_done) begin
						if (growth_q == '0) state_q <= S_SUM;
						else if (mid_q == '0) state_q <= S_DIV_W;
						else state_q <= S_EXP;
					end
				end
				S_EXP: state_q <= mul_ctl.start ? S_EXP_W : S_SUM;
				S_EXP_W: if (mul_done) state_q <= S_EXP;
				S_DIV_W: if (div_done) state_q <= S_SUM;
				S_SUM: state_q <= S_CMP;
				S_CMP: begin
					if (!neg && mag == edge_q) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_PROBE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					sample_q <= sample_value;
					lo_q <= '0;
					hi_q <= hbis_pkg::IDX_W'(count_eff) + 1'b1;
				end
			end
			S_PROBE: begin
				mid_q <= mid_full[hbis_pkg::CNT_W-1:0];
				if (hi_q <= lo_q) index_q <= lo_q - 1'b1;
			end
			S_LIN_W: begin
				if (mul_done) begin
					lin_q <= mul_res;
					term_q <= (growth_q == '0) ? '0 : scale_q;
					exp_cnt_q <= mid_q - 1'b1;
				end
			end
			S_EXP_W: begin
				if (mul_done) begin
					term_q <= mul_res;
					exp_cnt_q <= exp_cnt_q - 1'b1;
				end
			end
			S_DIV_W: if (div_done) term_q <= div_res;
			S_SUM: edge_q <= sum[hbis_pkg::VAL_W] ? hbis_pkg::SAT_MAX : sum[hbis_pkg::VAL_W-1:0];
			S_CMP: begin
				if (neg || mag < edge_q) hi_q <= {1'b0, mid_q};
				else if (mag > edge_q) lo_q <= {1'b0, mid_q} + 1'b1;
				else index_q <= {1'b0, mid_q};
			end
			default: ;
		endcase
	end

endmodule

@@ src/hbis_mul.sv @@
module hbis_mul #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hbis_pkg::mul_ctl_t                ctl,
	input  logic [hbis_pkg::VAL_W-1:0]        a,
	input  logic [hbis_pkg::GROWTH_W-1:0]     b,
	output logic                              done,
	output logic [hbis_pkg::VAL_W-1:0]        res
);

	localparam int ACC_W = hbis_pkg::VAL_W + hbis_pkg::GROWTH_W;
	localparam int HI_W = hbis_pkg::VAL_W - 32;

	logic [1:0]                       step_q;
	logic                             frac_q;
	logic [HI_W-1:0]                  ahi_q;
	logic [hbis_pkg::GROWTH_W-1:0]    b_q;
	logic [63:0]                      prod_s1;
	logic [ACC_W-1:0]                 acc_q;
	logic [31:0]                      mop_a;
	logic [31:0]                      mop_b;
	logic [63:0]                      prod;
	logic [ACC_W-1:0]                 shifted;

	// one shared 32x32 multiplier, low then high half of a
	assign mop_a = (step_q == 2'd0) ? a[31:0] : 32'(ahi_q);
	assign mop_b = (step_q == 2'd0) ? b : b_q;
	assign prod = 64'(mop_a) * 64'(mop_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
		end else begin
			case (step_q)
				2'd0: if (ctl.start) step_q <= 2'd1;
				default: step_q <= step_q + 2'd1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (step_q)
			2'd0: begin
				if (ctl.start) begin
					prod_s1 <= prod;
					ahi_q <= a[hbis_pkg::VAL_W-1:32];
					b_q <= b;
					frac_q <= ctl.frac;
				end
			end
			2'd1: begin
				acc_q <= ACC_W'(prod_s1);
				prod_s1 <= prod;
			end
			2'd2: acc_q <= acc_q + {prod_s1[ACC_W-33:0], 32'b0};
			default: ;
		endcase
	end

	assign shifted = frac_q ? (acc_q >> FRAC_BITS) : acc_q;
	assign done = (step_q == 2'd3);
	assign res = (|shifted[ACC_W-1:hbis_pkg::VAL_W]) ? hbis_pkg::SAT_MAX
		: shifted[hbis_pkg::VAL_W-1:0];

endmodule

@@ src/hbis_div.sv @@
module hbis_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [hbis_pkg::VAL_W-1:0]        a,
	input  logic [hbis_pkg::GROWTH_W-1:0]     g,
	output logic                              done,
	output logic [hbis_pkg::VAL_W-1:0]        res
);

	localparam int NW = hbis_pkg::VAL_W + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic                             busy_q;
	logic [CW-1:0]                    cnt_q;
	logic [NW-1:0]                    num_q;
	logic [31:0]                      rem_q;
	logic [31:0]                      g_q;
	logic [63:0]                      quo_q;
	logic                             ovf_q;
	logic [32:0]                      r2;
	logic                             qbit;

	// restoring division, one quotient bit per cycle
	assign r2 = {rem_q, num_q[NW-1]};
	assign qbit = (r2 >= {1'b0, g_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(NW);
		end else if (busy_q) begin
			if (cnt_q == '0) busy_q <= 1'b0;
			else cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NW'(a) << FRAC_BITS;
			rem_q <= '0;
			g_q <= g;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q && cnt_q != '0) begin
			num_q <= num_q << 1;
			rem_q <= qbit ? 32'(r2 - {1'b0, g_q}) : r2[31:0];
			quo_q <= {quo_q[62:0], qbit};
			ovf_q <= ovf_q | quo_q[63];
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign res = (ovf_q || quo_q[63]) ? hbis_pkg::SAT_MAX : quo_q[hbis_pkg::VAL_W-1:0];

endmodule

@@ src/hbis_checker.sv @@
module hbis_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 done,
	input logic signed [hbis_pkg::IDX_W-1:0]    bucket_index
);

	// an accepted transfer makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> bucket_index >= -12'sd1)
		else $error("bucket index below underflow");

endmodule

bind histogram_bucket_index_search hbis_checker u_hbis_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.bucket_index (bucket_index)
);

@@ tb/tb_histogram_bucket_index_search.sv @@
module tb_histogram_bucket_index_search;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_BK = 1024;
	localparam int FRAC = 16;
	localparam int IDLE_LIMIT = 400000;
	localparam logic [hbis_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED_A = 8'd4;
	localparam logic [hbis_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED_B = 8'hFF;

	class bucket_scoreboard;
		logic [hbis_pkg::IDX_W-1:0] expected_q[$];
		int errors = 0;

		function void note_sample(logic [hbis_pkg::IDX_W-1:0] idx);
			expected_q.push_back(idx);
		endfunction

		function void check_result(logic [hbis_pkg::IDX_W-1:0] got, realtime t);
			logic [hbis_pkg::IDX_W-1:0] want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected bucket_index %0d", t, $signed(got));
				return;
			end
			want = expected_q.pop_front();
			if (want !== got) begin
				errors++;
				$display("%0t: bucket_index expected %0d actual %0d", t, $signed(want),
					$signed(got));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [63:0] sample_value = '0;
	logic done;
	logic signed [hbis_pkg::IDX_W-1:0] bucket_index;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [hbis_pkg::CFG_ADDR_W-1:0] cfg_index = '0;
	logic [hbis_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [hbis_pkg::VAL_W-1:0] cur_width;
	logic [hbis_pkg::GROWTH_W-1:0] cur_growth;
	logic [hbis_pkg::VAL_W-1:0] cur_scale;
	logic [hbis_pkg::CNT_W-1:0] cur_count;

	bucket_scoreboard sb = new();
	bit gaps_on = 1'b1;
	int idle_cycles = 0;

	histogram_bucket_index_search #(.MAX_BUCKETS(MAX_BK), .FRAC_BITS(FRAC)) dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [hbis_pkg::VAL_W-1:0] mul_sat(logic [hbis_pkg::VAL_W-1:0] a,
			logic [31:0] b, int sh);
		logic [127:0] p;
		p = ({65'd0, a} * {96'd0, b}) >> sh;
		return (p > {65'd0, hbis_pkg::SAT_MAX}) ? hbis_pkg::SAT_MAX : p[hbis_pkg::VAL_W-1:0];
	endfunction

	function automatic logic [hbis_pkg::VAL_W-1:0] div_sat(logic [hbis_pkg::VAL_W-1:0] a,
			logic [31:0] g);
		logic [127:0] p;
		p = ({65'd0, a} << FRAC) / {96'd0, g};
		return (p > {65'd0, hbis_pkg::SAT_MAX}) ? hbis_pkg::SAT_MAX : p[hbis_pkg::VAL_W-1:0];
	endfunction

	function automatic logic [hbis_pkg::VAL_W-1:0] edge_value(int k);
		logic [hbis_pkg::VAL_W-1:0] sum;
		logic [hbis_pkg::VAL_W-1:0] term;
		logic [hbis_pkg::VAL_W:0] total;
		sum = mul_sat(cur_width, k, 0);
		if (cur_growth == 0) return sum;
		if (k == 0) begin
			term = div_sat(cur_scale, cur_growth);
		end else begin
			term = cur_scale;
			for (int n = 1; n < k && term != 0; n++) term = mul_sat(term, cur_growth, FRAC);
		end
		total = {1'b0, sum} + {1'b0, term};
		return (total > {1'b0, hbis_pkg::SAT_MAX}) ? hbis_pkg::SAT_MAX
			: total[hbis_pkg::VAL_W-1:0];
	endfunction

	function automatic int capped_count();
		return (cur_count > MAX_BK) ? MAX_BK : int'(cur_count);
	endfunction

	function automatic logic [hbis_pkg::IDX_W-1:0] classify_sample(logic [63:0] raw);
		logic [hbis_pkg::VAL_W-1:0] e;
		int lo;
		int hi;
		int mid;
		bit hit;
		lo = 0;
		hi = capped_count() + 1;
		hit = 0;
		while (hi > lo) begin
			mid = lo + ((hi - lo) >> 1);
			e = edge_value(mid);
			if (raw[63] || raw[62:0] < e) begin
				hi = mid;
			end else if (raw[62:0] > e) begin
				lo = mid + 1;
			end else begin
				lo = mid;
				hit = 1;
				break;
			end
		end
		return hit ? hbis_pkg::IDX_W'(lo) : hbis_pkg::IDX_W'(lo - 1);
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(bucket_index, $realtime);
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_histogram_bucket_index_search NOT OK");
			$finish;
		end
	end

	// leaves cfg_valid high; caller lowers it
	task automatic write_reg(logic [hbis_pkg::CFG_ADDR_W-1:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			hbis_pkg::REG_BUCKET_WIDTH: cur_width = data[hbis_pkg::VAL_W-1:0];
			hbis_pkg::REG_GROWTH_RATIO: cur_growth = data[hbis_pkg::GROWTH_W-1:0];
			hbis_pkg::REG_EXP_SCALE: cur_scale = data[hbis_pkg::VAL_W-1:0];
			hbis_pkg::REG_BUCKET_COUNT: cur_count = data[hbis_pkg::CNT_W-1:0];
			default: ;
		endcase
	endtask

	function automatic logic [63:0] junk_above(int w);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return ($urandom_range(0, 1) == 0) ? 64'd0 : (r & ~((64'd1 << w) - 1));
	endfunction

	task automatic configure(logic [62:0] w, logic [31:0] g, logic [62:0] s, logic [10:0] n);
		write_reg(hbis_pkg::REG_BUCKET_WIDTH, {1'b0, w} | junk_above(hbis_pkg::VAL_W));
		write_reg(hbis_pkg::REG_GROWTH_RATIO, {32'd0, g} | junk_above(hbis_pkg::GROWTH_W));
		write_reg(hbis_pkg::REG_EXP_SCALE, {1'b0, s} | junk_above(hbis_pkg::VAL_W));
		if ($urandom_range(0, 2) == 0)
			write_reg($urandom_range(0, 1) ? REG_UNMAPPED_A : REG_UNMAPPED_B,
				{$urandom, $urandom});
		write_reg(hbis_pkg::REG_BUCKET_COUNT, {53'd0, n} | junk_above(hbis_pkg::CNT_W));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// keeps start high after the transfer so back-to-back items need no toggle
	task automatic send_sample(logic [63:0] v);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		start <= 1'b1;
		sample_value <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_sample(classify_sample(v));
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_sample();
		logic [63:0] e;
		int k;
		case ($urandom_range(0, 7))
			0, 1: return {$urandom, $urandom};
			2: return {{32{1'b0}}, $urandom} >> $urandom_range(0, 31);
			default: begin
				k = $urandom_range(0, capped_count());
				e = {1'b0, edge_value(k)};
				return e + 64'($signed($urandom_range(0, 2)) - 1);
			end
		endcase
	endfunction

	task automatic random_phase(logic [62:0] w, logic [31:0] g, logic [62:0] s, logic [10:0] n,
			int items);
		configure(w, g, s, n);
		for (int i = 0; i < items; i++) send_sample(pick_sample());
		drain();
	endtask

	function automatic logic [62:0] rnd63();
		return 63'({$urandom, $urandom} >> $urandom_range(1, 50));
	endfunction

	initial begin
		logic [62:0] w;
		logic [31:0] g;
		logic [62:0] s;
		logic [10:0] n;
		cur_width = '0;
		cur_growth = '0;
		cur_scale = hbis_pkg::EXP_SCALE_RST;
		cur_count = hbis_pkg::BUCKET_COUNT_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset configuration: every edge sits at zero
		send_sample(64'd0);
		send_sample(64'd1);
		send_sample(64'hFFFF_FFFF_FFFF_FFFF);
		send_sample(64'h8000_0000_0000_0000);
		send_sample(64'h7FFF_FFFF_FFFF_FFFF);
		drain();

		// growing edges: hits and neighbors of each edge
		configure(63'd65536, 32'h0002_0000, 63'd65536, 11'd4);
		for (int k = 0; k <= 4; k++) begin
			send_sample({1'b0, edge_value(k)});
			send_sample({1'b0, edge_value(k)} - 64'd1);
		end
		send_sample({1'b0, edge_value(4)} + 64'd1);
		drain();

		// count zero, saturating extremes, shrinking growth
		configure(hbis_pkg::SAT_MAX, 32'hFFFF_FFFF, hbis_pkg::SAT_MAX, 11'd0);
		send_sample(64'h7FFF_FFFF_FFFF_FFFF);
		send_sample(64'h7FFF_FFFF_FFFF_FFFE);
		send_sample(64'd0);
		drain();
		random_phase(63'd0, 32'h0000_0001, 63'd65536, 11'd3, 20);
		random_phase(63'd1000, 32'h0000_8000, hbis_pkg::SAT_MAX, 11'd12, 40);

		// large counts: cheap without growth, a handful with growth
		random_phase(rnd63(), 32'd0, rnd63(), 11'd1024, 60);
		random_phase(63'd65536, 32'd0, 63'd0, 11'h7FF, 40);
		random_phase(63'd0, 32'h0000_4000, hbis_pkg::SAT_MAX, 11'd1500, 10);
		random_phase(63'd65536, 32'h0001_8000, 63'd65536, 11'h7FF, 3);

		for (int p = 0; p < 14; p++) begin
			case ($urandom_range(0, 3))
				0: w = 63'd0;
				1: w = hbis_pkg::SAT_MAX;
				2: w = 63'($urandom_range(1, 64)) << 16;
				default: w = rnd63();
			endcase
			case ($urandom_range(0, 4))
				0: g = 32'd0;
				1: g = 32'hFFFF_FFFF;
				2: g = 32'h0001_0000;
				3: g = $urandom_range(32'h8000, 32'h3_0000);
				default: g = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0: s = 63'd0;
				1: s = hbis_pkg::SAT_MAX;
				2: s = 63'd65536;
				default: s = rnd63();
			endcase
			n = 11'($urandom_range(0, 16));
			if (p == 13) gaps_on = 1'b0;
			random_phase(w, g, s, n, 105);
		end

		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("tb_histogram_bucket_index_search OK");
		else
			$display("tb_histogram_bucket_index_search NOT OK");
		$finish;
	end
endmodule

@@ files.f @@
src/hbis_pkg.sv
src/hbis_mul.sv
src/hbis_div.sv
src/histogram_bucket_index_search.sv
src/hbis_checker.sv
tb/tb_histogram_bucket_index_search.sv
